/* rtl/core/top_k_similarity_selector_top_macros.svh */
// Assertion macros for the top-k selector datapath.
`ifndef TOP_K_SIMILARITY_SELECTOR_TOP_MACROS_SVH
`define TOP_K_SIMILARITY_SELECTOR_TOP_MACROS_SVH

`ifndef SYNTH
`define TKS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tks assertion failed");
`define TKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tks assertion failed");
`else
`define TKS_ASSERT_SAME(lbl, ante, cons)
`define TKS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/tks_pkg.sv */
// Shared types and constants of the top-k similarity selector.
package tks_pkg;

  localparam int CFG_ADDR_BITS = 1;
  localparam int KUSED_BITS    = 5;

  localparam logic [CFG_ADDR_BITS-1:0] REG_QUERY_INDEX = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_K_USED      = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;  // a candidate request is accepted this cycle
    logic drain;   // move the head of the list into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register is empty or being taken
    logic at_last;   // the next drained rank is the last one of the run
  } status_t;

endpackage

/* rtl/core/tks_ctrl.sv */
// Controller for the top-k selector: accept phase and readout phase.
module tks_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tlast,
  output logic             s_tready,
  input  tks_pkg::status_t status,
  output tks_pkg::cmd_t    cmd
);

  typedef enum logic {ST_ACCEPT, ST_DRAIN} state_t;

  state_t state;

  always_comb begin
    cmd.insert = s_tvalid && s_tready;
    cmd.drain  = (state == ST_DRAIN) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACCEPT;
      s_tready <= 1'b0;
    end else begin
      unique case (state)
        ST_ACCEPT: begin
          s_tready <= 1'b1;
          // The end-of-query request is still inserted before readout starts.
          if (cmd.insert && s_tlast) begin
            state    <= ST_DRAIN;
            s_tready <= 1'b0;
          end
        end
        ST_DRAIN: begin
          if (cmd.drain && status.at_last) begin
            state    <= ST_ACCEPT;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_ACCEPT;
          s_tready <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/core/tks_datapath.sv */
// Datapath of the top-k selector: sorted list, insertion network, output register.
`include "top_k_similarity_selector_top_macros.svh"

module tks_datapath #(
  parameter int K_MAX      = 16,
  parameter int INDEX_BITS = 24,
  parameter int SCORE_BITS = 16,
  parameter int RANK_BITS  = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tks_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [INDEX_BITS-1:0]             cfg_data,
  input  logic [INDEX_BITS-1:0]             cand_index,
  input  logic [SCORE_BITS-1:0]             cand_score,
  input  tks_pkg::cmd_t                     cmd,
  output tks_pkg::status_t                  status,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic                              m_tlast,
  output logic [RANK_BITS-1:0]              rank,
  output logic [INDEX_BITS-1:0]             neighbor_index,
  output logic [SCORE_BITS-1:0]             neighbor_score
);

  localparam int K_RST = (K_MAX < 10) ? K_MAX : 10;
  localparam logic [RANK_BITS-1:0] K_LAST_RST = RANK_BITS'(K_RST - 1);

  logic [INDEX_BITS-1:0] query_index;
  logic [RANK_BITS-1:0]  k_last;
  logic [RANK_BITS-1:0]  k_last_next;
  logic [RANK_BITS-1:0]  drain_rank;

  logic [INDEX_BITS-1:0] kept_index [K_MAX];
  logic [SCORE_BITS-1:0] kept_score [K_MAX];

  logic [K_MAX-1:0] ge;
  logic [K_MAX-1:0] prev_ge;
  logic [K_MAX-1:0] beats;
  logic             enter;
  logic             clear;

  // Clamp a new k_used to 1..K_MAX and keep it as the last kept rank.
  always_comb begin
    int ku;
    ku = int'(cfg_data[tks_pkg::KUSED_BITS-1:0]);
    if (ku == 0) begin
      k_last_next = '0;
    end else if (ku > K_MAX) begin
      k_last_next = RANK_BITS'(K_MAX - 1);
    end else begin
      k_last_next = RANK_BITS'(ku - 1);
    end
  end

  assign clear = cfg_we && (cfg_addr == tks_pkg::REG_K_USED);

  // The list is sorted by descending score, so the entries that the candidate
  // beats form a suffix of the kept ranks. The first of them takes the
  // candidate and the rest take their upper neighbor.
  always_comb begin
    for (int j = 0; j < K_MAX; j++) begin
      ge[j]    = kept_score[j] >= cand_score;
      beats[j] = !ge[j] && (RANK_BITS'(j) <= k_last);
    end
    prev_ge[0] = 1'b1;
    for (int j = 1; j < K_MAX; j++) begin
      prev_ge[j] = ge[j-1];
    end
    enter = cmd.insert && (cand_index != query_index) && (|beats);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_index <= '0;
      k_last      <= K_LAST_RST;
    end else if (cfg_we) begin
      if (cfg_addr == tks_pkg::REG_QUERY_INDEX) begin
        query_index <= cfg_data;
      end else if (cfg_addr == tks_pkg::REG_K_USED) begin
        k_last <= k_last_next;
      end
    end
  end

  // Readout shifts the list toward rank 0 and fills zeros at the tail, so a
  // full readout leaves the list cleared.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int j = 0; j < K_MAX; j++) begin
        kept_index[j] <= '0;
        kept_score[j] <= '0;
      end
    end else if (cmd.drain) begin
      for (int j = 1; j < K_MAX; j++) begin
        kept_index[j-1] <= kept_index[j];
        kept_score[j-1] <= kept_score[j];
      end
      kept_index[K_MAX-1] <= '0;
      kept_score[K_MAX-1] <= '0;
    end else if (enter) begin
      for (int j = 0; j < K_MAX; j++) begin
        if (beats[j] && prev_ge[j]) begin
          kept_index[j] <= cand_index;
          kept_score[j] <= cand_score;
        end
      end
      for (int j = 1; j < K_MAX; j++) begin
        if (beats[j] && !prev_ge[j]) begin
          kept_index[j] <= kept_index[j-1];
          kept_score[j] <= kept_score[j-1];
        end
      end
    end
  end

  always_comb begin
    status.out_free = !m_tvalid || m_tready;
    status.at_last  = drain_rank == k_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      drain_rank <= '0;
    end else if (cmd.drain) begin
      m_tvalid   <= 1'b1;
      drain_rank <= status.at_last ? '0 : drain_rank + 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain) begin
      rank           <= drain_rank;
      neighbor_index <= kept_index[0];
      neighbor_score <= kept_score[0];
      m_tlast        <= status.at_last;
    end
  end

  `TKS_ASSERT_SAME(a_no_overlap, cmd.insert, !cmd.drain)
  `TKS_ASSERT_SAME(a_drain_when_free, cmd.drain, !m_tvalid || m_tready)
  `TKS_ASSERT_NEXT(a_rank_wraps, cmd.drain && status.at_last, drain_rank == '0)
  `TKS_ASSERT_NEXT(a_list_cleared, cmd.drain && status.at_last, kept_score[0] == '0)

endmodule

/* rtl/core/top_k_similarity_selector_top.sv */
// Top level of the top-k similarity selector.
// Keeps the k best candidates of a query (k from the k_used register, clamped
// to 1..K_MAX) in a register list sorted by descending score, with a parallel
// compare-and-shift network that takes one candidate request every cycle. A
// candidate whose index equals query_index is dropped; a score ties below any
// equal score already kept. The request marked with s_tlast is inserted first,
// then the list is read out best first: k results, one per cycle through the
// output register while m_tready holds, the last one marked with m_tlast. The
// input stalls during readout. Readout leaves the list all zero; writing
// k_used also clears it. Unfilled ranks report index and score zero.
module top_k_similarity_selector_top #(
  parameter int K_MAX      = 16,
  parameter int INDEX_BITS = 24,
  parameter int SCORE_BITS = 16,
  localparam int RANK_BITS = (K_MAX > 1) ? $clog2(K_MAX) : 1,
  localparam int IN_W      = ((INDEX_BITS + SCORE_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((RANK_BITS + INDEX_BITS + SCORE_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tks_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [INDEX_BITS-1:0]             cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: cand_index, cand_score, zero fill.
  input  logic [IN_W-1:0]                   s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // Fields from bit 0: rank, neighbor_index, neighbor_score, zero fill.
  output logic [OUT_W-1:0]                  m_tdata,
  output logic                              m_tlast
);

  tks_pkg::cmd_t    cmd;
  tks_pkg::status_t status;

  logic [RANK_BITS-1:0]  rank;
  logic [INDEX_BITS-1:0] neighbor_index;
  logic [SCORE_BITS-1:0] neighbor_score;

  tks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tks_datapath #(
    .K_MAX      (K_MAX),
    .INDEX_BITS (INDEX_BITS),
    .SCORE_BITS (SCORE_BITS),
    .RANK_BITS  (RANK_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .cand_index     (s_tdata[INDEX_BITS-1:0]),
    .cand_score     (s_tdata[INDEX_BITS +: SCORE_BITS]),
    .cmd            (cmd),
    .status         (status),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .m_tlast        (m_tlast),
    .rank           (rank),
    .neighbor_index (neighbor_index),
    .neighbor_score (neighbor_score)
  );

  always_comb begin
    m_tdata                                      = '0;
    m_tdata[RANK_BITS-1:0]                       = rank;
    m_tdata[RANK_BITS +: INDEX_BITS]             = neighbor_index;
    m_tdata[RANK_BITS + INDEX_BITS +: SCORE_BITS] = neighbor_score;
  end

endmodule

/* tb/tb_top_k_similarity_selector_top.sv */
// Self-checking testbench for the top-k similarity selector with a built-in ranking predictor.
module tb_top_k_similarity_selector_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int K_MAX      = 16;
  localparam int INDEX_BITS = 24;
  localparam int SCORE_BITS = 16;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 48;
  localparam int SETTLE     = 8;
  localparam int LONG_STALL = 150;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic [SCORE_BITS-1:0] score;
    logic                  eoq;
  } cand_t;

  typedef struct packed {
    logic [3:0]            rank;
    logic [INDEX_BITS-1:0] index;
    logic [SCORE_BITS-1:0] score;
    logic                  last;
  } neighbor_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [tks_pkg::CFG_ADDR_BITS-1:0] cfg_addr = tks_pkg::REG_QUERY_INDEX;
  logic [INDEX_BITS-1:0]             cfg_data = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  // Fields from bit 0: cand_index, cand_score.
  logic [IN_W-1:0]                   s_tdata = '0;
  logic                              s_tlast = 1'b0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  // Fields from bit 0: rank, neighbor_index, neighbor_score, zero fill.
  logic [OUT_W-1:0]                  m_tdata;
  logic                              m_tlast;

  top_k_similarity_selector_top #(
    .K_MAX     (K_MAX),
    .INDEX_BITS(INDEX_BITS),
    .SCORE_BITS(SCORE_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state: register copies and the sorted best list.
  logic [INDEX_BITS-1:0]          query_reg = '0;
  logic [tks_pkg::KUSED_BITS-1:0] k_reg = 5'd10;
  logic [INDEX_BITS-1:0] best_index [K_MAX];
  logic [SCORE_BITS-1:0] best_score [K_MAX];

  cand_t     cand_q [$];
  neighbor_t ranked_q [$];
  cand_t     tx_item;

  int  errors = 0;
  int  items_queued = 0;
  int  items_taken = 0;
  int  idle_cycles = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  rx_stall = 0;
  bit  quiet = 1'b0;
  bit  stall_req = 1'b0;
  logic in_taken = 1'b0;

  function automatic int list_depth();
    if (k_reg == 0) return 1;
    if (k_reg > K_MAX) return K_MAX;
    return int'(k_reg);
  endfunction

  task automatic clear_best();
    for (int i = 0; i < K_MAX; i++) begin
      best_index[i] = '0;
      best_score[i] = '0;
    end
  endtask

  // Insert one candidate in the sorted list; on end of query queue the readout.
  task automatic rank_candidate(cand_t c);
    int        k;
    int        pos;
    neighbor_t r;
    k = list_depth();
    if (c.index != query_reg && c.score > best_score[k-1]) begin
      pos = 0;
      while (pos < k && best_score[pos] >= c.score) pos++;
      for (int j = k - 1; j > pos; j--) begin
        best_index[j] = best_index[j-1];
        best_score[j] = best_score[j-1];
      end
      best_index[pos] = c.index;
      best_score[pos] = c.score;
    end
    if (c.eoq) begin
      for (int i = 0; i < k; i++) begin
        r.rank  = 4'(i);
        r.index = best_index[i];
        r.score = best_score[i];
        r.last  = (i == k - 1);
        ranked_q.push_back(r);
      end
      clear_best();
    end
  endtask

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_neighbor(neighbor_t got);
    neighbor_t exp;
    if (ranked_q.size() == 0) begin
      note_error($sformatf("unexpected result rank %0d index %h score %h last %b",
                           got.rank, got.index, got.score, got.last));
    end else begin
      exp = ranked_q.pop_front();
      if (got.rank !== exp.rank || got.index !== exp.index ||
          got.score !== exp.score || got.last !== exp.last) begin
        note_error($sformatf({"expected rank %0d index %h score %h last %b, ",
                              "got rank %0d index %h score %h last %b"},
                             exp.rank, exp.index, exp.score, exp.last,
                             got.rank, got.index, got.score, got.last));
      end
    end
  endtask

  // Request driver: holds an item until it is taken, with random gap bursts.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        tx_gap = $urandom_range(1, 14) - 1;
        s_tvalid <= 1'b0;
      end else if (cand_q.size() > 0) begin
        tx_item = cand_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {tx_item.score, tx_item.index};
        s_tlast  <= tx_item.eoq;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side ready: random stall bursts plus one long hold on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (stall_req) begin
        rx_stall  = LONG_STALL;
        stall_req = 1'b0;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        rx_gap = $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: feeds accepted requests to the predictor and checks results.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        items_taken++;
        rank_candidate('{index: s_tdata[23:0], score: s_tdata[39:24], eoq: s_tlast});
      end
      if (m_tvalid && m_tready) begin
        check_neighbor('{rank: m_tdata[3:0], index: m_tdata[27:4],
                         score: m_tdata[43:28], last: m_tlast});
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic push_cand(logic [INDEX_BITS-1:0] idx, logic [SCORE_BITS-1:0] scr,
                           logic eoq);
    cand_q.push_back('{index: idx, score: scr, eoq: eoq});
    items_queued++;
  endtask

  task automatic drain_wait();
    while (items_taken != items_queued || ranked_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [tks_pkg::CFG_ADDR_BITS-1:0] addr,
                           logic [INDEX_BITS-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    if (addr == tks_pkg::REG_QUERY_INDEX) begin
      query_reg = data;
    end else begin
      k_reg = data[tks_pkg::KUSED_BITS-1:0];
      clear_best();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [INDEX_BITS-1:0] random_index();
    case ($urandom_range(0, 7))
      0:       return query_reg;
      1:       return INDEX_BITS'($urandom_range(0, 15));
      default: return INDEX_BITS'($urandom);
    endcase
  endfunction

  // Small score ranges make ties frequent.
  function automatic logic [SCORE_BITS-1:0] random_score();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4:    return SCORE_BITS'($urandom_range(0, 7));
      default:    return SCORE_BITS'($urandom);
    endcase
  endfunction

  task automatic add_random_query();
    int mode;
    int n;
    mode = $urandom_range(0, 9);
    if (mode == 0) n = 1;
    else if (mode == 1) n = $urandom_range(25, 40);
    else n = $urandom_range(2, 20);
    for (int i = 0; i < n; i++) push_cand(random_index(), random_score(), i == n - 1);
  endtask

  int phase_k [6] = '{31, 1, -1, 16, 0, 7};
  int start_count;

  initial begin
    clear_best();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: query index 0, ten kept ranks.
    push_cand(24'h0, 16'hFFFF, 1'b0);
    push_cand(24'h5, 16'h0000, 1'b0);
    push_cand(24'hFFFFFF, 16'hFFFF, 1'b0);
    push_cand(24'h1, 16'h0100, 1'b0);
    push_cand(24'h2, 16'h0100, 1'b0);
    push_cand(24'h3, 16'h0200, 1'b0);
    push_cand(24'h4, 16'h0001, 1'b0);
    push_cand(24'h0, 16'h0500, 1'b1);
    drain_wait();

    // A zero k is taken as one; a tie must not displace the kept entry.
    write_reg(tks_pkg::REG_K_USED, 24'h0);
    push_cand(24'h7, 16'h0009, 1'b0);
    push_cand(24'h8, 16'h0009, 1'b0);
    push_cand(24'h9, 16'h000A, 1'b1);
    push_cand(24'h6, 16'h0003, 1'b0);
    drain_wait();

    // k above the list size with high data bits set; the write clears the list.
    write_reg(tks_pkg::REG_K_USED, 24'h5A5A5F);
    write_reg(tks_pkg::REG_QUERY_INDEX, 24'hFFFFFF);
    push_cand(24'hFFFFFF, 16'hFFFF, 1'b0);
    push_cand(24'h0, 16'hFFFF, 1'b0);
    for (int i = 0; i < 10; i++) push_cand(random_index(), random_score(), 1'b0);
    push_cand(24'h123456, 16'h8000, 1'b1);
    push_cand(24'h000042, 16'h4242, 1'b1);

    for (int p = 0; p < 6; p++) begin
      drain_wait();
      if (p == 5) quiet = 1'b1;
      if (p == 2) write_reg(tks_pkg::REG_QUERY_INDEX, 24'h0);
      else write_reg(tks_pkg::REG_QUERY_INDEX, INDEX_BITS'($urandom));
      if (phase_k[p] >= 0) begin
        write_reg(tks_pkg::REG_K_USED,
                  {(INDEX_BITS - tks_pkg::KUSED_BITS)'($urandom),
                   tks_pkg::KUSED_BITS'(phase_k[p])});
      end
      start_count = items_queued;
      if (p == 1) begin
        @(posedge clk);
        stall_req = 1'b1;
      end
      while (items_queued - start_count < 50) begin
        add_random_query();
        // The sender holds off once until every result of the phase so far is out.
        if (p == 4 && items_queued - start_count >= 25 && items_queued - start_count < 45) begin
          drain_wait();
          start_count = start_count - 20;
        end
      end
      // Leave a partly filled list behind for the next phase.
      if (p < 5 && $urandom_range(0, 1) == 1) begin
        for (int i = 0; i < $urandom_range(1, 3); i++) begin
          push_cand(random_index(), random_score(), 1'b0);
        end
      end
    end

    drain_wait();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
